// ===== sv/sbst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbst_pkg;

  localparam int CAPACITY_DEFAULT = 64;

  localparam logic [15:0] EMPTY_DEFAULT_RESET = 16'd1000;
  localparam logic [15:0] RANGE_CEILING_RESET = 16'd10000;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 24;

  // configuration register indexes
  localparam logic CFG_EMPTY_DEFAULT = 1'b0;
  localparam logic CFG_RANGE_CEILING = 1'b1;

  typedef enum logic [2:0] {
    OP_APPEND    = 3'd0,
    OP_LOOKUP    = 3'd1,
    OP_INDEX     = 3'd2,
    OP_SET       = 3'd3,
    OP_RANGE_MIN = 3'd4,
    OP_CLEAR     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MSCAN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [15:0]        speed;
    logic [15:0]        entry_index;
    logic signed [31:0] position_end;
    logic signed [31:0] position;
    logic [2:0]         op;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  index_out;
    logic [15:0] speed_out;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/sbst_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/sbst_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbst_engine
  import sbst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire item_t                       item,
  input  wire logic [15:0]                 empty_default,
  input  wire logic [15:0]                 min_ceiling,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output res_t                             res,
  output logic                             pos_we,
  output logic                             spd_we,
  output logic [$clog2(CAPACITY)-1:0]      waddr,
  output logic signed [31:0]               pos_wdata,
  output logic [15:0]                      spd_wdata,
  output logic [$clog2(CAPACITY)-1:0]      raddr,
  input  wire logic signed [31:0]          rd_pos,
  input  wire logic [15:0]                 rd_spd
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic signed [31:0] first_pos, first_pos_next;
  logic signed [31:0] last_pos, last_pos_next;
  op_t                op_r, op_r_next;
  logic signed [31:0] target, target_next;
  logic signed [31:0] pos_end_r, pos_end_r_next;
  logic signed [31:0] mid_r, mid_r_next;
  logic [IW-1:0]      addr_cnt, addr_cnt_next;
  logic [IW-1:0]      cmp_idx, cmp_idx_next;
  logic               dvalid, dvalid_next;
  logic [15:0]        min_r, min_r_next;
  logic               found_r, found_r_next;
  res_t               res_r, res_r_next;

  logic [CW-1:0]      last_c;
  logic [IW-1:0]      last_idx;
  logic               is_empty;
  logic               is_full;
  logic signed [32:0] mid_sum;
  logic               at_last;
  logic               scan_done;
  logic               in_range;
  logic               found_upd;
  logic [15:0]        min_upd;
  logic [IW+5:0]      idx_wide;

  assign last_c    = count - CW'(1);
  assign last_idx  = last_c[IW-1:0];
  assign is_empty  = (count == '0);
  assign is_full   = (count == CW'(CAPACITY));
  assign mid_sum   = {item.position[31], item.position}
                   + {item.position_end[31], item.position_end};
  assign at_last   = dvalid && (cmp_idx == last_idx);
  assign scan_done = dvalid && ((rd_pos >= target) || (cmp_idx == last_idx));
  assign in_range  = dvalid && (rd_pos >= target) && (rd_pos <= pos_end_r);
  assign found_upd = found_r || in_range;
  assign min_upd   = (in_range && (rd_spd < min_r)) ? rd_spd : min_r;
  assign idx_wide  = {6'b0, cmp_idx};

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_OUT);
  assign res       = res_r;
  assign raddr     = addr_cnt;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_OUT;
          if ((item.op == OP_LOOKUP || item.op == OP_INDEX) && !is_empty) begin
            state_next = S_SCAN;
          end else if (item.op == OP_RANGE_MIN && !is_empty) begin
            if (item.position > last_pos || item.position_end < first_pos) begin
              state_next = S_SCAN;
            end else begin
              state_next = S_MSCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_OUT;
        end
      end
      S_MSCAN: begin
        if (at_last) begin
          state_next = found_upd ? S_OUT : S_SCAN;
        end
      end
      S_OUT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next     = count;
    first_pos_next = first_pos;
    last_pos_next  = last_pos;
    op_r_next      = op_r;
    target_next    = target;
    pos_end_r_next = pos_end_r;
    mid_r_next     = mid_r;
    min_r_next     = min_r;
    found_r_next   = found_r;
    res_r_next     = res_r;
    dvalid_next    = 1'b0;
    cmp_idx_next   = addr_cnt;
    addr_cnt_next  = '0;
    pos_we         = 1'b0;
    spd_we         = 1'b0;
    waddr          = count[IW-1:0];
    pos_wdata      = item.position;
    spd_wdata      = item.speed;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_r_next        = op_t'(item.op);
          target_next      = item.position;
          pos_end_r_next   = item.position_end;
          mid_r_next       = mid_sum[32:1];
          min_r_next       = min_ceiling;
          found_r_next     = 1'b0;
          res_r_next       = '0;
          res_r_next.status = ST_DONE;
          unique case (item.op)
            OP_APPEND: begin
              if (is_full || (!is_empty && item.position < last_pos)) begin
                res_r_next.status = ST_IGNORED;
              end else begin
                pos_we        = 1'b1;
                spd_we        = 1'b1;
                count_next    = count + CW'(1);
                last_pos_next = item.position;
                if (is_empty) begin
                  first_pos_next = item.position;
                end
              end
            end
            OP_LOOKUP, OP_INDEX, OP_RANGE_MIN: begin
              if (is_empty) begin
                res_r_next.status = ST_EMPTY;
                if (item.op != OP_INDEX) begin
                  res_r_next.speed_out = empty_default;
                end
              end else if (item.op == OP_RANGE_MIN && item.position <= last_pos &&
                           item.position_end < first_pos) begin
                // range wholly before the table: the first entry answers
                target_next = first_pos;
              end
            end
            OP_SET: begin
              if (32'(item.entry_index) >= 32'(count)) begin
                res_r_next.status = ST_IGNORED;
              end else begin
                spd_we = 1'b1;
                waddr  = item.entry_index[IW-1:0];
              end
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
              res_r_next.status = ST_IGNORED;
            end
          endcase
        end
      end
      S_SCAN, S_MSCAN: begin
        // stream one entry per cycle; the read data is registered and trails its address
        dvalid_next   = 1'b1;
        addr_cnt_next = (addr_cnt == last_idx) ? addr_cnt : addr_cnt + IW'(1);
        if (state == S_SCAN) begin
          if (scan_done) begin
            if (op_r == OP_INDEX) begin
              res_r_next.index_out = idx_wide[5:0];
            end else begin
              res_r_next.speed_out = rd_spd;
            end
          end
        end else begin
          found_r_next = found_upd;
          min_r_next   = min_upd;
          if (at_last) begin
            if (found_upd) begin
              res_r_next.speed_out = min_upd;
            end else begin
              // nothing inside the range: restart as a lookup at the midpoint
              target_next   = mid_r;
              dvalid_next   = 1'b0;
              addr_cnt_next = '0;
            end
          end
        end
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      dvalid   <= 1'b0;
      addr_cnt <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dvalid   <= dvalid_next;
      addr_cnt <= addr_cnt_next;
    end
    first_pos <= first_pos_next;
    last_pos  <= last_pos_next;
    op_r      <= op_r_next;
    target    <= target_next;
    pos_end_r <= pos_end_r_next;
    mid_r     <= mid_r_next;
    cmp_idx   <= cmp_idx_next;
    min_r     <= min_r_next;
    found_r   <= found_r_next;
    res_r     <= res_r_next;
  end

endmodule

`default_nettype wire

// ===== sv/sorted_breakpoint_speed_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Append, set, clear, ignored ops, empty-table answers: result state, then the output register.
// Lookup and index lookup: scan entries in order, one per cycle, and stop on the first hit.
// Range min scans every entry; a range wholly outside the table scans as a lookup;
// with no entry in range, it then rescans as a lookup at the midpoint.
// The next input transfer can come once the result is in the output register; s_tready only in idle.
// rst (synchronous): table empty, config to defaults; table memory is not cleared.
module sorted_breakpoint_speed_table
  import sbst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // op[2:0], position[34:3], position_end[66:35], entry_index[82:67], speed[98:83], zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // speed_out[15:0], index_out[21:16], status[23:22]
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [15:0]            cfg_data
);

  localparam int IW = $clog2(CAPACITY);

  logic [15:0]        empty_default;
  logic [15:0]        min_ceiling;
  item_t              item;
  res_t               res;
  logic               res_valid;
  logic               res_ready;
  logic               pos_we;
  logic               spd_we;
  logic [IW-1:0]      waddr;
  logic signed [31:0] pos_wdata;
  logic [15:0]        spd_wdata;
  logic [IW-1:0]      raddr;
  logic signed [31:0] rd_pos;
  logic [15:0]        rd_spd;
  res_t               out_r;

  assign item = s_tdata[$bits(item_t)-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_default <= EMPTY_DEFAULT_RESET;
      min_ceiling   <= RANGE_CEILING_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EMPTY_DEFAULT: empty_default <= cfg_data;
        CFG_RANGE_CEILING: min_ceiling   <= cfg_data;
        default: ;
      endcase
    end
  end

  sbst_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (waddr),
    .wdata (pos_wdata),
    .raddr (raddr),
    .rdata (rd_pos)
  );

  sbst_ram #(.WIDTH(16), .DEPTH(CAPACITY)) u_spd_ram (
    .clk   (clk),
    .we    (spd_we),
    .waddr (waddr),
    .wdata (spd_wdata),
    .raddr (raddr),
    .rdata (rd_spd)
  );

  sbst_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .item          (item),
    .empty_default (empty_default),
    .min_ceiling   (min_ceiling),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .pos_we        (pos_we),
    .spd_we        (spd_we),
    .waddr         (waddr),
    .pos_wdata     (pos_wdata),
    .spd_wdata     (spd_wdata),
    .raddr         (raddr),
    .rd_pos        (rd_pos),
    .rd_spd        (rd_spd)
  );

  // output register: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign m_tdata = out_r;

endmodule

`default_nettype wire

// ===== tb/sv/sorted_breakpoint_speed_table_tb.sv =====
`timescale 1ns / 1ps

module sorted_breakpoint_speed_table_tb;
  import sbst_pkg::*;

  localparam int PAD = IN_TDATA_W - $bits(item_t);
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD = 500;
  localparam int POS_MIN = 32'h8000_0000;
  localparam int POS_MAX = 32'h7FFF_FFFF;
  localparam logic [2:0] OP_UNDEF_A = 3'd6;
  localparam logic [2:0] OP_UNDEF_B = 3'd7;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = 1'b0;
  logic [15:0]            cfg_data = '0;

  sorted_breakpoint_speed_table #(.CAPACITY(CAPACITY_DEFAULT)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // breakpoint table as the block should hold it
  int          brk_pos [CAPACITY_DEFAULT];
  logic [15:0] brk_speed [CAPACITY_DEFAULT];
  int          brk_count = 0;
  logic [15:0] cfg_default = EMPTY_DEFAULT_RESET;
  logic [15:0] cfg_ceiling = RANGE_CEILING_RESET;

  item_t pending_cmds[$];
  res_t  expected_replies[$];

  // what the command generator believes the table looks like
  int gen_count = 0;
  int gen_first = 0;
  int gen_last = 0;
  int gen_items = 0;

  bit gaps_on = 1'b1;
  bit in_fire = 1'b0;
  int gap_left = 0;
  int hold_left = 0;
  int hold_request = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;
  res_t got_reply;
  res_t want_reply;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int first_at_or_after(int p);
    for (int i = 0; i < brk_count; i++)
      if (brk_pos[i] >= p) return i;
    return brk_count - 1;
  endfunction

  function automatic res_t table_answer(item_t it);
    res_t        r;
    int          p;
    int          pe;
    logic [15:0] lo;
    bit          found;
    longint      sum;
    r = '0;
    r.status = ST_DONE;
    p = it.position;
    pe = it.position_end;
    case (it.op)
      OP_APPEND: begin
        if (brk_count >= CAPACITY_DEFAULT || (brk_count > 0 && p < brk_pos[brk_count-1])) begin
          r.status = ST_IGNORED;
        end else begin
          brk_pos[brk_count] = p;
          brk_speed[brk_count] = it.speed;
          brk_count++;
        end
      end
      OP_LOOKUP: begin
        if (brk_count == 0) begin
          r.speed_out = cfg_default;
          r.status = ST_EMPTY;
        end else begin
          r.speed_out = brk_speed[first_at_or_after(p)];
        end
      end
      OP_INDEX: begin
        if (brk_count == 0) r.status = ST_EMPTY;
        else r.index_out = 6'(first_at_or_after(p));
      end
      OP_SET: begin
        if (int'(it.entry_index) >= brk_count) r.status = ST_IGNORED;
        else brk_speed[it.entry_index] = it.speed;
      end
      OP_RANGE_MIN: begin
        if (brk_count == 0) begin
          r.speed_out = cfg_default;
          r.status = ST_EMPTY;
        end else if (p > brk_pos[brk_count-1]) begin
          r.speed_out = brk_speed[brk_count-1];
        end else if (pe < brk_pos[0]) begin
          r.speed_out = brk_speed[0];
        end else begin
          found = 1'b0;
          lo = cfg_ceiling;
          for (int i = 0; i < brk_count; i++) begin
            if (brk_pos[i] >= p && brk_pos[i] <= pe) begin
              found = 1'b1;
              if (brk_speed[i] < lo) lo = brk_speed[i];
            end
          end
          if (found) begin
            r.speed_out = lo;
          end else begin
            // midpoint rounds toward minus infinity
            sum = longint'(p) + longint'(pe);
            r.speed_out = brk_speed[first_at_or_after(int'(sum >>> 1))];
          end
        end
      end
      OP_CLEAR: brk_count = 0;
      default: r.status = ST_IGNORED;
    endcase
    return r;
  endfunction

  function automatic int clamp32(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return int'(v);
  endfunction

  function automatic item_t mk(logic [2:0] op, int p, int pe, logic [15:0] idx,
                               logic [15:0] spd);
    item_t it;
    it.op = op;
    it.position = p;
    it.position_end = pe;
    it.entry_index = idx;
    it.speed = spd;
    return it;
  endfunction

  function automatic item_t rand_item();
    return mk(3'($urandom_range(0, 7)), int'($urandom()), int'($urandom()),
              16'($urandom()), 16'($urandom()));
  endfunction

  function automatic logic [15:0] pick_speed();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic int near_pos();
    longint span;
    longint v;
    span = longint'(gen_last) - longint'(gen_first);
    case ($urandom_range(0, 7))
      0: v = int'($urandom());
      1: v = POS_MIN;
      2: v = POS_MAX;
      3: v = longint'(gen_first) - int'($urandom_range(0, 50));
      4: v = longint'(gen_last) + int'($urandom_range(0, 50));
      default: v = longint'(gen_first) + longint'($urandom()) % (span + 1);
    endcase
    return clamp32(v);
  endfunction

  task automatic add_item(item_t it);
    int p;
    p = it.position;
    case (it.op)
      OP_APPEND: begin
        if (gen_count < CAPACITY_DEFAULT && (gen_count == 0 || p >= gen_last)) begin
          if (gen_count == 0) gen_first = p;
          gen_last = p;
          gen_count++;
        end
      end
      OP_CLEAR: begin
        gen_count = 0;
        gen_first = 0;
        gen_last = 0;
      end
      default: ;
    endcase
    pending_cmds.push_back(it);
    gen_items++;
  endtask

  // clear, build a sorted table, then query it
  task automatic gen_episode();
    item_t  it;
    longint p;
    int     fill;
    int     nq;
    int     k;
    it = rand_item();
    it.op = OP_CLEAR;
    add_item(it);
    fill = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 67) : $urandom_range(1, 12);
    case ($urandom_range(0, 3))
      0: p = longint'(POS_MIN) + int'($urandom_range(0, 100));
      1: p = int'($urandom());
      2: p = longint'(POS_MAX) - int'($urandom_range(0, 3000));
      default: p = longint'($urandom_range(0, 4000)) - 2000;
    endcase
    for (int i = 0; i < fill; i++) begin
      it = rand_item();
      it.op = OP_APPEND;
      it.speed = pick_speed();
      if (gen_count > 0 && $urandom_range(0, 15) == 0) begin
        it.position = clamp32(longint'(gen_last) - int'($urandom_range(1, 100)));
      end else begin
        it.position = clamp32(p);
        p = p + (($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 500)));
      end
      add_item(it);
    end
    nq = $urandom_range(4, 24);
    for (int i = 0; i < nq; i++) begin
      it = rand_item();
      k = $urandom_range(0, 19);
      if (k < 4) begin
        it.op = OP_LOOKUP;
        it.position = near_pos();
      end else if (k < 8) begin
        it.op = OP_INDEX;
        it.position = near_pos();
      end else if (k < 11) begin
        it.op = OP_SET;
        it.speed = pick_speed();
        if ($urandom_range(0, 4) != 0) it.entry_index = 16'($urandom_range(0, gen_count + 1));
      end else if (k < 17) begin
        it.op = OP_RANGE_MIN;
        it.position = near_pos();
        case ($urandom_range(0, 2))
          0: it.position_end = near_pos();
          1: it.position_end = clamp32(longint'(it.position) + int'($urandom_range(0, 100)));
          default: it.position_end = clamp32(longint'(it.position) - int'($urandom_range(1, 50)));
        endcase
      end else if (k == 17) begin
        it.op = OP_APPEND;
        it.position = clamp32(longint'(gen_last) + int'($urandom_range(0, 30)) - 3);
      end else if (k == 18) begin
        it.op = $urandom_range(0, 1) ? OP_UNDEF_A : OP_UNDEF_B;
      end
      add_item(it);
    end
  endtask

  task automatic random_phase(int n);
    int target;
    target = gen_items + n;
    while (gen_items < target) gen_episode();
  endtask

  // hold until every command is out and every reply is back
  task automatic settle();
    while (pending_cmds.size() != 0 || s_tvalid || expected_replies.size() != 0)
      @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_EMPTY_DEFAULT) cfg_default = val;
    else cfg_ceiling = val;
  endtask

  // command driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 11);
        s_tvalid <= 1'b0;
      end else begin
        s_tdata <= {{PAD{1'b0}}, pending_cmds.pop_front()};
        s_tvalid <= 1'b1;
      end
    end
  end

  // reply receiver
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(0, 11);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // predict on each command transfer, check each reply transfer, watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready)
        expected_replies.push_back(table_answer(item_t'(s_tdata[$bits(item_t)-1:0])));
      if (m_tvalid && m_tready) begin
        got_reply = res_t'(m_tdata);
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("reply with nothing expected: speed %0d index %0d status %0d",
                     got_reply.speed_out, got_reply.index_out, got_reply.status);
        end else begin
          want_reply = expected_replies.pop_front();
          if (got_reply.speed_out !== want_reply.speed_out ||
              got_reply.index_out !== want_reply.index_out ||
              got_reply.status !== want_reply.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("reply mismatch: speed %0d/%0d index %0d/%0d status %0d/%0d (exp/got)",
                       want_reply.speed_out, got_reply.speed_out,
                       want_reply.index_out, got_reply.index_out,
                       want_reply.status, got_reply.status);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("sorted_breakpoint_speed_table_tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table, undefined ops
    add_item(mk(OP_LOOKUP, 0, 0, 16'd0, 16'd0));
    add_item(mk(OP_INDEX, 0, 0, 16'd0, 16'd0));
    add_item(mk(OP_RANGE_MIN, 0, 0, 16'd0, 16'd0));
    add_item(mk(OP_SET, 0, 0, 16'd0, 16'd5));
    add_item(mk(OP_UNDEF_A, 0, 0, 16'd0, 16'd0));
    add_item(mk(OP_UNDEF_B, -1, -1, 16'hFFFF, 16'hFFFF));
    // appends: equal position accepted, behind the tail dropped; then lookups, index lookups, sets
    add_item(mk(OP_APPEND, -1000000, 0, 16'd0, 16'd0));
    add_item(mk(OP_APPEND, -100, 0, 16'd0, 16'hFFFF));
    add_item(mk(OP_APPEND, -100, 0, 16'd0, 16'd500));
    add_item(mk(OP_APPEND, -200, 0, 16'd0, 16'd9));
    add_item(mk(OP_APPEND, 1000, 0, 16'd0, 16'd12000));
    add_item(mk(OP_LOOKUP, POS_MIN, 0, 16'd0, 16'd0));
    add_item(mk(OP_LOOKUP, POS_MAX, 0, 16'd0, 16'd0));
    add_item(mk(OP_INDEX, POS_MAX, 0, 16'd0, 16'd0));
    add_item(mk(OP_INDEX, -99, 0, 16'd0, 16'd0));
    add_item(mk(OP_SET, 0, 0, 16'd1, 16'd7));
    add_item(mk(OP_SET, 0, 0, 16'd4, 16'd3));
    add_item(mk(OP_SET, 0, 0, 16'hFFFF, 16'd3));
    // range min: inside, after the table, before it, empty gap, reversed, capped
    add_item(mk(OP_RANGE_MIN, -100, 1000, 16'd0, 16'd0));
    add_item(mk(OP_RANGE_MIN, 1001, POS_MAX, 16'd0, 16'd0));
    add_item(mk(OP_RANGE_MIN, POS_MIN, -2000000, 16'd0, 16'd0));
    add_item(mk(OP_RANGE_MIN, -50, 500, 16'd0, 16'd0));
    add_item(mk(OP_RANGE_MIN, 500, -500, 16'd0, 16'd0));
    add_item(mk(OP_RANGE_MIN, 1000, 1000, 16'd0, 16'd0));
    add_item(mk(OP_CLEAR, 0, 0, 16'd0, 16'd0));
    add_item(mk(OP_LOOKUP, 0, 0, 16'd0, 16'd0));

    settle();
    write_reg(CFG_EMPTY_DEFAULT, 16'h0000);
    write_reg(CFG_RANGE_CEILING, 16'hFFFF);
    random_phase(600);

    settle();
    write_reg(CFG_EMPTY_DEFAULT, 16'hFFFF);
    write_reg(CFG_RANGE_CEILING, 16'h0000);
    random_phase(400);

    settle();
    write_reg(CFG_EMPTY_DEFAULT, 16'($urandom()));
    write_reg(CFG_RANGE_CEILING, 16'($urandom()));
    random_phase(500);
    // stall the reply side while commands keep coming
    @(posedge clk);
    hold_request = LONG_HOLD;

    settle();
    write_reg(CFG_EMPTY_DEFAULT, 16'd12345);
    write_reg(CFG_RANGE_CEILING, 16'd30000);
    gaps_on = 1'b0;
    random_phase(400);

    settle();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("sorted_breakpoint_speed_table_tb: clean");
    end else begin
      $display("sorted_breakpoint_speed_table_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sorted_breakpoint_speed_table.f =====
sv/sbst_pkg.sv
sv/sbst_ram.sv
sv/sbst_engine.sv
sv/sorted_breakpoint_speed_table.sv
tb/sv/sorted_breakpoint_speed_table_tb.sv
